// ===== design/dtfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtfp_pkg: shared types and constants of the decimal text converter
// Character codes, queue sizing, the item passed from front to back, and the
// saturating multiply-by-ten-and-add step used by the accumulator and scaler.
// ----------------------------------------------------------------------------
package dtfp_pkg;

	// Default for the largest number of fraction digits kept
	localparam int MAX_FRAC_DIGITS_DEF = 18;

	// Reset value of the frac_digits register
	localparam logic [4:0] FRAC_RESET = 5'd8;

	// ASCII codes
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Front-to-back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Classified character as handed to the back end
	typedef struct packed {
		logic       is_digit;  // digit to fold into the magnitude
		logic [3:0] digit;
		logic       neg;       // number is negative (as of this character)
		logic       last;      // closes the number
		logic [4:0] scale;     // powers of ten still to apply at the end
	} dtfp_item_t;

	// Magnitude with its sticky saturation flag
	typedef struct packed {
		logic [63:0] mag;
		logic        ovf;
	} dtfp_acc_t;

	// mag*10 + d, saturating at 2^63-1 (positive) or 2^63 (negative)
	function automatic dtfp_acc_t push_digit(input logic [63:0] mag, input logic ovf,
		input logic neg, input logic [3:0] d);
		logic [67:0] t;
		logic [67:0] cap;
		dtfp_acc_t   r;
		t   = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {64'd0, d};
		cap = {5'd0, 63'h7FFF_FFFF_FFFF_FFFF} + {67'd0, neg};
		if (ovf || (t > cap)) begin
			r.mag = cap[63:0];
			r.ovf = 1'b1;
		end else begin
			r.mag = t[63:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== design/decimal_text_to_fixed_point.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point: streaming decimal text to scaled integer
// Characters of a decimal number in, one signed 64-bit value scaled by
// 10^frac_digits out per number, saturating with an overflow flag.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ----------------------------
//  in        input      in_valid / in_stall   char_code[7:0], last
//  out       output     out_valid / out_stall value[63:0] signed, overflow
//  cfg       input      cfg_valid / cfg_ready cfg_data[4:0] (frac_digits)
//
//  One character is accepted per cycle while in_stall is low; the digit loop
//  is a single multiply-by-ten-and-add per cycle in the accumulator while the
//  back end advances. A result passes through the queue, the scaler entry, one
//  x10 stage per fraction digit and the output register.
//  arst_n clears all control state; frac_digits resets to 8.
//  out_stall freezes the back end; the 4-entry queue keeps absorbing
//  characters, and in_stall rises once it is full.
//
module decimal_text_to_fixed_point #(
	parameter int MAX_FRAC_DIGITS = dtfp_pkg::MAX_FRAC_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] value,
	output logic               overflow,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data
);

	logic                 push;
	dtfp_pkg::dtfp_item_t push_item;
	logic                 q_full;
	logic                 pop;
	logic                 q_valid;
	dtfp_pkg::dtfp_item_t q_item;

	// classifier and configuration register
	dtfp_front #(
		.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (push_item),
		.q_full    (q_full)
	);

	// decoupling queue
	dtfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// arithmetic back end
	dtfp_back #(
		.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.overflow  (overflow)
	);

endmodule

// ===== design/dtfp_front.sv =====
// ----------------------------------------------------------------------------
// dtfp_front: character classifier
// Accepts one character per cycle unless q_full, tracks sign, point and fraction
// count, pushes digits and number ends to the queue, and holds frac_digits.
// ----------------------------------------------------------------------------
module dtfp_front #(
	parameter int MAX_FRAC_DIGITS = dtfp_pkg::MAX_FRAC_DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// character input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           char_code,
	input  logic                 last,
	// configuration write
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [4:0]           cfg_data,
	// queue side
	output logic                 push,
	output dtfp_pkg::dtfp_item_t item,
	input  logic                 q_full
);

	logic [4:0] frac_digits_q;
	logic       at_start_q;
	logic       neg_q;
	logic       seen_point_q;
	logic [4:0] frac_taken_q;

	logic       accept;
	logic [4:0] fd;
	logic       minus_first;
	logic       point_first;
	logic       is_num;
	logic       frac_room;
	logic       keep;
	logic       frac_inc;
	logic [4:0] frac_now;
	logic       neg_now;

	assign in_stall  = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !q_full;

	// effective fraction digit count
	assign fd = (frac_digits_q > 5'(MAX_FRAC_DIGITS)) ? 5'(MAX_FRAC_DIGITS) : frac_digits_q;

	// classify the character
	assign minus_first = at_start_q && (char_code == dtfp_pkg::CH_MINUS);
	assign point_first = (char_code == dtfp_pkg::CH_POINT) && !seen_point_q;
	assign is_num      = (char_code >= dtfp_pkg::CH_ZERO) && (char_code <= dtfp_pkg::CH_NINE);
	assign frac_room   = frac_taken_q < fd;
	assign keep        = is_num && (!seen_point_q || frac_room);
	assign frac_inc    = is_num && seen_point_q && frac_room;
	assign frac_now    = frac_taken_q + {4'd0, frac_inc};
	assign neg_now     = neg_q || minus_first;

	// item toward the back end; ignored characters are dropped unless they end a number
	assign push          = accept && (keep || last);
	assign item.is_digit = keep;
	assign item.digit    = char_code[3:0];
	assign item.neg      = neg_now;
	assign item.last     = last;
	assign item.scale    = (fd > frac_now) ? (fd - frac_now) : 5'd0;

	// per-number state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q   <= 1'b1;
			neg_q        <= 1'b0;
			seen_point_q <= 1'b0;
			frac_taken_q <= 5'd0;
		end else if (accept) begin
			if (last) begin
				at_start_q   <= 1'b1;
				neg_q        <= 1'b0;
				seen_point_q <= 1'b0;
				frac_taken_q <= 5'd0;
			end else begin
				at_start_q   <= 1'b0;
				neg_q        <= neg_now;
				seen_point_q <= seen_point_q || point_first;
				frac_taken_q <= frac_now;
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_digits_q <= dtfp_pkg::FRAC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frac_digits_q <= cfg_data;
		end
	end

endmodule

// ===== design/dtfp_queue.sv =====
// ----------------------------------------------------------------------------
// dtfp_queue: short FIFO between classifier and arithmetic back end
// Lets the front keep taking characters while the back end is stalled.
// ----------------------------------------------------------------------------
module dtfp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dtfp_pkg::dtfp_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 q_valid,
	output dtfp_pkg::dtfp_item_t q_item
);

	dtfp_pkg::dtfp_item_t              mem_q [dtfp_pkg::QUEUE_DEPTH];
	logic [dtfp_pkg::QUEUE_AW-1:0]     wptr_q;
	logic [dtfp_pkg::QUEUE_AW-1:0]     rptr_q;
	logic [dtfp_pkg::QUEUE_AW:0]       count_q;
	logic                              do_push;
	logic                              do_pop;

	assign full    = (count_q == (dtfp_pkg::QUEUE_AW+1)'(dtfp_pkg::QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/dtfp_back.sv =====
// ----------------------------------------------------------------------------
// dtfp_back: accumulator, scaling pipeline and output register
// Folds digits into the magnitude, then passes each finished number through one
// conditional multiply-by-ten stage per possible missing fraction digit.
// ----------------------------------------------------------------------------
module dtfp_back #(
	parameter int MAX_FRAC_DIGITS = dtfp_pkg::MAX_FRAC_DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// queue side
	input  logic                 q_valid,
	input  dtfp_pkg::dtfp_item_t q_item,
	output logic                 pop,
	// result output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [63:0]   value,
	output logic                 overflow
);

	typedef struct packed {
		logic [63:0] mag;
		logic        ovf;
		logic        neg;
		logic [4:0]  scale;
	} scl_t;

	logic [63:0]        mag_q;
	logic               ovf_q;
	dtfp_pkg::dtfp_acc_t upd;

	scl_t               scl_s     [MAX_FRAC_DIGITS+1];
	logic [MAX_FRAC_DIGITS:0] scl_vld_s;

	logic               out_valid_q;
	logic signed [63:0] value_q;
	logic               overflow_q;
	logic               adv;

	// whole back end advances unless a result is held
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && q_valid;

	// digit update
	assign upd = q_item.is_digit ?
		dtfp_pkg::push_digit(mag_q, ovf_q, q_item.neg, q_item.digit) : {mag_q, ovf_q};

	// accumulator, cleared after a number ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= 64'd0;
			ovf_q <= 1'b0;
		end else if (pop) begin
			if (q_item.last) begin
				mag_q <= 64'd0;
				ovf_q <= 1'b0;
			end else begin
				mag_q <= upd.mag;
				ovf_q <= upd.ovf;
			end
		end
	end

	// scaler entry
	always_ff @(posedge clk) begin
		if (adv) begin
			scl_s[0] <= {upd.mag, upd.ovf, q_item.neg, q_item.scale};
		end
	end

	// valid bits of the scaler
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_vld_s <= '0;
		end else if (adv) begin
			scl_vld_s <= {scl_vld_s[MAX_FRAC_DIGITS-1:0], pop && q_item.last};
		end
	end

	// one conditional x10 per stage
	for (genvar i = 0; i < MAX_FRAC_DIGITS; i++) begin : g_scale
		dtfp_pkg::dtfp_acc_t mul;
		dtfp_pkg::dtfp_acc_t nxt;

		assign mul = dtfp_pkg::push_digit(scl_s[i].mag, scl_s[i].ovf, scl_s[i].neg, 4'd0);
		assign nxt = (scl_s[i].scale > 5'(i)) ? mul : {scl_s[i].mag, scl_s[i].ovf};

		always_ff @(posedge clk) begin
			if (adv) begin
				scl_s[i+1] <= {nxt.mag, nxt.ovf, scl_s[i].neg, scl_s[i].scale};
			end
		end
	end

	// output register with sign applied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= scl_vld_s[MAX_FRAC_DIGITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_q    <= scl_s[MAX_FRAC_DIGITS].neg ?
				$signed(64'd0 - scl_s[MAX_FRAC_DIGITS].mag) : $signed(scl_s[MAX_FRAC_DIGITS].mag);
			overflow_q <= scl_s[MAX_FRAC_DIGITS].ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign overflow  = overflow_q;

endmodule

// ===== tb/sv/tb_decimal_text_to_fixed_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_text_to_fixed_point: self-checking bench for the text converter
// Streams decimal numbers one character per transaction. A local predictor
// tracks magnitude, sign, point and fraction count and queues the expected
// scaled value per number. Random sender gaps, receiver stalls, and
// frac_digits changes, including two taken in the middle of a number.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_fixed_point;

	localparam int FRAC_CAP     = dtfp_pkg::MAX_FRAC_DIGITS_DEF;
	localparam int SETTLE       = 2 * (FRAC_CAP + 3) + 8;  // back end drain margin
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 850;
	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef logic [7:0] char_q_t[$];

	typedef struct {
		logic signed [63:0] value;
		logic               ovf;
	} fixed_result_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         char_code = 8'h00;
	logic               last = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [63:0] value;
	logic               overflow;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [4:0]         cfg_data = 5'd0;

	decimal_text_to_fixed_point u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.overflow  (overflow),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: mirror of the register and of the number in progress
	logic [4:0]    frac_reg = dtfp_pkg::FRAC_RESET;
	logic [63:0]   acc_mag = '0;
	logic          acc_neg = 1'b0;
	logic          acc_point = 1'b0;
	int            acc_taken = 0;
	logic          acc_start = 1'b1;
	logic          acc_ovf = 1'b0;
	fixed_result_t pending_results[$];

	int  mismatches = 0;
	int  cycles = 0;
	int  burst_left = 0;
	bit  steady_sender = 1'b1;

	// One mismatch line, counted
	task automatic report_mismatch(input string what, input logic [63:0] exp_v,
		input logic [63:0] got_v);
		mismatches++;
		$display("[%0t] MISMATCH %s: expected %h got %h", $time, what, exp_v, got_v);
	endtask

	// mag*10 + d with saturation at the sign dependent limit
	task automatic fold_digit(input logic [3:0] d);
		logic [63:0] cap;
		cap = POS_MAX + {63'd0, acc_neg};
		if (acc_ovf || acc_mag > (cap - {60'd0, d}) / 64'd10) begin
			acc_mag = cap;
			acc_ovf = 1'b1;
		end else begin
			acc_mag = acc_mag * 64'd10 + {60'd0, d};
		end
	endtask

	// Advance the predictor by one accepted character
	task automatic convert_char(input logic [7:0] ch, input logic fin);
		logic        first;
		int          fd;
		logic [7:0]  dv;
		fixed_result_t r;
		first = acc_start;
		fd = (frac_reg > FRAC_CAP) ? FRAC_CAP : int'(frac_reg);
		dv = ch - dtfp_pkg::CH_ZERO;
		acc_start = 1'b0;
		if (first && ch == dtfp_pkg::CH_MINUS) begin
			acc_neg = 1'b1;
		end else if (ch == dtfp_pkg::CH_POINT && !acc_point) begin
			acc_point = 1'b1;
		end else if (ch >= dtfp_pkg::CH_ZERO && ch <= dtfp_pkg::CH_NINE) begin
			if (!acc_point) begin
				fold_digit(dv[3:0]);
			end else if (acc_taken < fd) begin
				fold_digit(dv[3:0]);
				acc_taken++;
			end
		end
		if (fin) begin
			// scale by the missing powers of ten, then sign
			for (int k = acc_taken; k < fd; k++)
				fold_digit(4'd0);
			r.value = acc_neg ? (64'd0 - acc_mag) : acc_mag;
			r.ovf = acc_ovf;
			pending_results.push_back(r);
			acc_mag = '0;
			acc_neg = 1'b0;
			acc_point = 1'b0;
			acc_taken = 0;
			acc_start = 1'b1;
			acc_ovf = 1'b0;
		end
	endtask

	// One character transaction, with burst/gap pacing in front of it
	task automatic send_char(input logic [7:0] ch, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady_sender) begin
				gap = $urandom_range(0, 6);
				repeat (gap) begin
					@(negedge clk);
					in_valid <= 1'b0;
				end
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid  <= 1'b1;
		char_code <= ch;
		last      <= fin;
		do @(posedge clk); while (in_stall);
		convert_char(ch, fin);
	endtask

	task automatic send_seq(input char_q_t q, input bit close);
		foreach (q[i])
			send_char(q[i], close && (i == q.size() - 1));
	endtask

	task automatic send_text(input string s, input bit close = 1'b1);
		char_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		send_seq(q, close);
	endtask

	// Stop sending and wait for every expected result; optionally settle
	task automatic hold_until_drained(input bit settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		if (settle)
			repeat (SETTLE) @(posedge clk);
	endtask

	// frac_digits register write, only with the block idle
	task automatic write_frac(input logic [4:0] fd);
		hold_until_drained(1'b1);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= fd;
		do @(posedge clk); while (!cfg_ready);
		frac_reg = fd;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random number: mostly well formed with random content, some noise
	task automatic build_random_number(output char_q_t q);
		int r;
		int n;
		int pos;
		q = {};
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 2) == 0)
			q.push_back(dtfp_pkg::CH_MINUS);
		r = $urandom_range(0, 19);
		n = (r < 15) ? $urandom_range(0, 6) : (r < 18) ? $urandom_range(7, 14)
			: $urandom_range(15, 22);
		repeat (n) q.push_back(dtfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 2) != 0) begin
			q.push_back(dtfp_pkg::CH_POINT);
			r = $urandom_range(0, 9);
			n = (r < 7) ? $urandom_range(0, 8) : $urandom_range(9, 22);
			repeat (n) q.push_back(dtfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		end
		// occasional stray byte anywhere in the number
		if ($urandom_range(0, 4) == 0) begin
			pos = $urandom_range(0, q.size());
			q.insert(pos, 8'($urandom_range(0, 255)));
		end
		if (q.size() == 0)
			q.push_back(dtfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	// Receiver stall pattern: modes of random length
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			stall_left = $urandom_range(50, 300);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			default:     out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// Result checker
	always @(posedge clk) begin
		fixed_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'd0, value);
			end else begin
				exp_r = pending_results.pop_front();
				if (value !== exp_r.value)
					report_mismatch("value", exp_r.value, value);
				if (overflow !== exp_r.ovf)
					report_mismatch("overflow", {63'd0, exp_r.ovf}, {63'd0, overflow});
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Reset default of 8 fraction digits, signs, points, ignored characters
	task automatic test_default_frac();
		send_text("0");
		send_text("-0");
		send_text("123.456");
		send_text("-123.456");
		send_text("1..2");           // second point ignored
		send_text("1-2");            // minus only counts first
		send_text("a1x.2");          // other characters do not shift weights
		send_text("-");              // no digits
		send_text(".");
		send_text("7.123456789012"); // fraction truncated
		send_char(8'h00, 1'b0);      // char_code extremes
		send_char(8'hFF, 1'b0);
		send_char(dtfp_pkg::CH_NINE, 1'b1);
		send_text("-92233720368.54775808");  // exactly the negative extreme
		send_text("99999999999999999999");   // overflow
	endtask

	// Extremes of frac_digits, saturation at both signs
	task automatic test_frac_extremes();
		write_frac(5'd0);
		send_text("9223372036854775807");
		send_text("9223372036854775808");
		send_text("-9223372036854775808");
		send_text("-9223372036854775809");
		send_text("3.9");
		write_frac(5'd18);
		send_text("9.223372036854775807");
		send_text("10");
		send_text("-9.2233720368547758085");
		write_frac(5'd31);           // above the cap, acts as the cap
		send_text("1.5");
		send_text("-.000000000000000001");
		write_frac(5'd19);
		send_text("2");
	endtask

	// Register changed while a number is open
	task automatic test_mid_number_config();
		write_frac(5'd8);
		send_text("12.3", 1'b0);
		write_frac(5'd2);
		send_text("456");
		write_frac(5'd5);
		send_text("-1.2345", 1'b0);
		write_frac(5'd2);            // already more fraction digits than kept
		send_text("6");
	endtask

	// Long random streams over changing settings and pacing
	task automatic test_random_streams();
		char_q_t q;
		int      sent;
		int      chunk_end;
		int      phase;
		bit      drained_once;
		logic [4:0] fd;
		sent = 0;
		phase = 0;
		drained_once = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			case (phase % 5)
				0: fd = 5'd0;
				1: fd = 5'd18;
				2: fd = 5'd31;
				default: fd = 5'($urandom_range(0, 31));
			endcase
			write_frac(fd);
			steady_sender = (phase % 3 == 0);
			chunk_end = sent + $urandom_range(100, 200);
			while (sent < chunk_end && sent < RANDOM_ITEMS) begin
				build_random_number(q);
				send_seq(q, 1'b1);
				sent += q.size();
				// sender holds off once until everything has come back
				if (phase == 2 && !drained_once && sent > chunk_end - 60) begin
					hold_until_drained(1'b0);
					drained_once = 1'b1;
				end
			end
			phase++;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		steady_sender = 1'b0;
		test_default_frac();
		test_frac_extremes();
		test_mid_number_config();
		test_random_streams();
		hold_until_drained(1'b1);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
design/dtfp_pkg.sv
design/dtfp_front.sv
design/dtfp_queue.sv
design/dtfp_back.sv
design/decimal_text_to_fixed_point.sv
tb/sv/tb_decimal_text_to_fixed_point.sv
